FILE: sv/bsp_pkg.sv
package bsp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 5;
  localparam logic [31:0] KINV_Q32 = 32'd2608131496;

  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 40;
  localparam int DIV_CW = 7;

  localparam logic ACT_PROJECT = 1'b0;
  localparam logic ACT_COLUMN = 1'b1;

  localparam logic [7:0] FOV_RST = 8'd60;
  localparam logic [10:0] CELL_RST = 11'd64;
  localparam logic [7:0] DOV_RST = 8'd8;
  localparam logic [11:0] RAYS_RST = 12'd320;
  localparam logic [11:0] SCR_W_RST = 12'd640;
  localparam logic [11:0] SCR_H_RST = 12'd480;
  localparam logic [12:0] TEX_W_RST = 13'd64;
  localparam logic [12:0] TEX_H_RST = 13'd64;

  typedef enum logic [2:0] {
    CFG_FOV, CFG_CELL, CFG_DOV, CFG_RAYS, CFG_SCR_W, CFG_SCR_H, CFG_TEX_W, CFG_TEX_H
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_VEC_INIT, S_VEC, S_CHECK, S_ROT_INIT, S_ROT, S_DEP, S_CEN_MUL, S_CEN_DIV,
    S_SS_DIV, S_SY_MUL, S_SX_MUL, S_SX_DIV, S_HW_MUL, S_HW_DIV, S_SH_DIV, S_COL,
    S_TX_DIV, S_DX_DIV, S_DW_DIV, S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [DIV_CW-1:0] count;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/bsp_mul.sv
module bsp_mul (
  input  logic clk,
  input  logic rst,
  input  bsp_pkg::mul_req_t req,
  output logic done,
  output logic [bsp_pkg::MUL_PW-1:0] product
);
  import bsp_pkg::*;

  logic busy;
  logic [$clog2(MUL_BW)-1:0] cnt;
  logic [MUL_AW-1:0] a_reg;
  logic [MUL_AW:0] sum;

  // shift-add, one multiplier bit a cycle, lsb first
  always_comb begin
    sum = {1'b0, product[MUL_PW-1:MUL_BW]} + (product[0] ? {1'b0, a_reg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == ($clog2(MUL_BW))'(MUL_BW - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(MUL_BW))'(MUL_BW - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      product <= {{MUL_AW{1'b0}}, req.b};
    end else if (busy) begin
      product <= {sum, product[MUL_BW-1:1]};
    end
  end

endmodule

FILE: sv/bsp_div.sv
module bsp_div (
  input  logic clk,
  input  logic rst,
  input  bsp_pkg::div_req_t req,
  output logic done,
  output logic [bsp_pkg::DIV_NW-1:0] quotient
);
  import bsp_pkg::*;

  logic busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0] sh;
  logic [DIV_DW+1:0] diff;

  // restoring division, one quotient bit a cycle; dividend comes left-aligned
  always_comb begin
    sh = {rem, num[DIV_NW-1]};
    diff = {1'b0, sh} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == DIV_CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[DIV_NW-2:0], 1'b0};
      rem <= diff[DIV_DW+1] ? sh[DIV_DW-1:0] : diff[DIV_DW-1:0];
      quotient <= {quotient[DIV_NW-2:0], ~diff[DIV_DW+1]};
    end
  end

endmodule

FILE: sv/billboard_sprite_projector.sv
// projection item: two 16-step cordic passes, five 32-step serial multiplies, five restoring divides
// of 22 to 61 quotient bits; a hidden sprite stops after the first cordic pass
// column query: three restoring divides when the strip is drawn, none when it is not
// one item at a time; a result waiting at the output adds its stall to the next item
// the next item is taken while the last result waits at the output
// sync reset: registers to defaults, sprite hidden, stored depth 1.0, no result pending
module billboard_sprite_projector (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [12:0] cfg_data,
  input  logic item_valid,
  output logic item_ready,
  input  logic action,
  input  logic signed [31:0] sprite_x,
  input  logic signed [31:0] sprite_y,
  input  logic signed [31:0] viewer_x,
  input  logic signed [31:0] viewer_y,
  input  logic [15:0] viewer_angle,
  input  logic [15:0] sprite_scale,
  input  logic [11:0] column,
  input  logic [31:0] column_depth,
  output logic result_valid,
  input  logic result_ready,
  output logic visible,
  output logic signed [15:0] center_column,
  output logic [31:0] depth,
  output logic [15:0] sprite_height,
  output logic signed [16:0] top_row,
  output logic [7:0] shade,
  output logic column_drawn,
  output logic [11:0] texture_column,
  output logic [11:0] dest_x,
  output logic [11:0] dest_width
);
  import bsp_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t state, state_next;
  mul_req_t mul_req;
  div_req_t div_req;
  logic mul_done, div_done;
  logic [MUL_PW-1:0] mul_prod;
  logic [DIV_NW-1:0] div_quo;
  logic launched;
  logic load;

  logic [7:0] cfg_fov, cfg_dov;
  logic [10:0] cfg_cell;
  logic [11:0] cfg_rays, cfg_scr_w, cfg_scr_h;
  logic [12:0] cfg_tex_w, cfg_tex_h;
  logic [7:0] fov_n, dov_n;
  logic [10:0] cell_n;
  logic [11:0] rays_n, scr_w_n;
  logic [12:0] tex_w_n, tex_h_n;

  logic is_visible;
  logic signed [15:0] centre_ray;
  logic [31:0] sprite_depth;
  logic [14:0] half_width_rays;

  logic act;
  logic [15:0] ang, scl;
  logic [11:0] col;
  logic [31:0] cdep;
  logic signed [43:0] dx, dy, x, y;
  logic [31:0] z, d;
  logic [STEP_W-1:0] step;
  logic hid, drawn;
  logic [31:0] dep;
  logic signed [15:0] cen;
  logic [39:0] ss;
  logic [47:0] sy;
  logic [50:0] sxw;
  logic [14:0] hw;
  logic [7:0] shade_r;
  logic [15:0] off, span;
  logic [11:0] tx, dxo, dwo;

  logic signed [32:0] dxw, dyw;
  logic signed [43:0] xs, ys;
  logic [31:0] at, dcalc, rot_a, rot_sum, rot_r;
  logic [1:0] rot_k;
  logic hidden, x_nonpos;
  logic signed [41:0] dd, v;
  logic [41:0] av;
  logic [21:0] cen_q;
  logic signed [22:0] cen_s;
  logic [22:0] cell_h;
  logic [18:0] cell_dov;
  logic [34:0] c_lim, c_diff;
  logic [42:0] sh_num;
  logic signed [17:0] st, en, iv;
  logic drawn_c;
  logic [28:0] txp;
  logic [12:0] tx_lim, tx_c;
  logic [23:0] ixw;
  logic [12:0] wr;
  logic [23:0] a_sum;
  logic signed [49:0] t_full;
  logic signed [33:0] tf;
  logic signed [16:0] top_c;
  logic [15:0] hgt_c;

  always_comb begin
    fov_n = (cfg_fov == '0) ? 8'd1 : cfg_fov;
    cell_n = (cfg_cell == '0) ? 11'd1 : cfg_cell;
    dov_n = (cfg_dov == '0) ? 8'd1 : cfg_dov;
    rays_n = (cfg_rays == '0) ? 12'd1 : cfg_rays;
    scr_w_n = (cfg_scr_w == '0) ? 12'd1 : cfg_scr_w;
    tex_w_n = (cfg_tex_w == '0) ? 13'd1 : cfg_tex_w;
    tex_h_n = (cfg_tex_h == '0) ? 13'd1 : cfg_tex_h;
  end

  always_comb begin
    dxw = {sprite_x[31], sprite_x} - {viewer_x[31], viewer_x};
    dyw = {sprite_y[31], sprite_y} - {viewer_y[31], viewer_y};
    xs = x >>> step;
    ys = y >>> step;
    at = atan_entry(step);
    dcalc = z - {ang, 16'h0};
    hidden = ($signed(dcalc) > 32'sh4000_0000) || ($signed(dcalc) < -32'sh4000_0000);
    x_nonpos = x[43] || (x == '0);
    // heading turned to within an eighth turn by whole quarter turns first
    rot_a = 32'h0 - {ang, 16'h0};
    rot_sum = rot_a + 32'h2000_0000;
    rot_k = rot_sum[31:30];
    rot_r = rot_a - {rot_k, 30'h0};
    // 360*d + fov*2^31, the centre column numerator before the ray count
    dd = {{10{d[31]}}, d};
    v = (dd <<< 8) + (dd <<< 6) + (dd <<< 5) + (dd <<< 3) + ({34'h0, fov_n} << 31);
    av = v[41] ? 42'(-v) : 42'(v);
    cen_q = div_quo[21:0];
    cen_s = v[41] ? -$signed({1'b0, cen_q}) : $signed({1'b0, cen_q});
    cell_h = {12'h0, cell_n} * {11'h0, cfg_scr_h};
    cell_dov = {8'h0, cell_n} * {11'h0, dov_n};
    c_lim = {cell_dov, 16'h0};
    c_diff = c_lim - {3'b000, dep};
    sh_num = ({8'h0, c_diff} << 8) - {8'h0, c_diff};
    st = {{2{centre_ray[15]}}, centre_ray} - $signed({3'b000, half_width_rays});
    en = {{2{centre_ray[15]}}, centre_ray} + $signed({3'b000, half_width_rays});
    iv = $signed({6'h0, col});
    drawn_c = is_visible && (iv >= st) && (iv < en) && (col < rays_n) && (sprite_depth < cdep);
    txp = {13'h0, off} * {16'h0, tex_w_n};
    tx_lim = tex_w_n - 13'd1;
    tx_c = (div_quo[28:0] > {16'h0, tx_lim}) ? tx_lim : div_quo[12:0];
    ixw = {12'h0, col} * {12'h0, scr_w_n};
    wr = {1'b0, scr_w_n} + {1'b0, rays_n} - 13'd1;
    // top row: trunc((H/2 + S/2^17)*2^16 - height) / 2^16
    a_sum = {13'h0, cfg_scr_h[11:1]} + {1'b0, ss[39:17]};
    t_full = $signed({10'h0, a_sum, 16'h0}) - $signed({2'b00, sy});
    tf = t_full[49:16];
    if (t_full[49] && (t_full[15:0] != '0)) tf = tf + 34'sd1;
    if (tf > 34'sd65535) top_c = 17'sd65535;
    else if (tf < -34'sd65536) top_c = -17'sd65536;
    else top_c = tf[16:0];
    hgt_c = (sy[47:32] != '0) ? 16'hFFFF : sy[31:16];
  end

  always_comb begin
    state_next = state;
    mul_req = '0;
    div_req = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = (action == ACT_COLUMN) ? S_COL : S_VEC_INIT;
      end
      S_VEC_INIT: state_next = S_VEC;
      S_VEC: if (step == LAST_STEP) state_next = S_CHECK;
      S_CHECK: state_next = hidden ? S_FIN : S_ROT_INIT;
      S_ROT_INIT: state_next = S_ROT;
      S_ROT: if (step == LAST_STEP) state_next = S_DEP;
      S_DEP: begin
        if (x_nonpos) begin
          state_next = S_CEN_MUL;
        end else begin
          mul_req.start = !launched;
          mul_req.a = {20'h0, x};
          mul_req.b = KINV_Q32;
          if (mul_done) state_next = S_CEN_MUL;
        end
      end
      S_CEN_MUL: begin
        mul_req.start = !launched;
        mul_req.a = {22'h0, av};
        mul_req.b = {20'h0, rays_n};
        if (mul_done) state_next = S_CEN_DIV;
      end
      S_CEN_DIV: begin
        div_req.start = !launched;
        div_req.count = DIV_CW'(22);
        div_req.dividend = {mul_prod[53:32], 42'h0};
        div_req.divisor = {32'h0, fov_n};
        if (div_done) state_next = S_SS_DIV;
      end
      S_SS_DIV: begin
        div_req.start = !launched;
        div_req.count = DIV_CW'(55);
        div_req.dividend = {cell_h, 41'h0};
        div_req.divisor = {8'h0, dep};
        if (div_done) state_next = S_SY_MUL;
      end
      S_SY_MUL: begin
        mul_req.start = !launched;
        mul_req.a = {24'h0, ss};
        mul_req.b = {16'h0, scl};
        if (mul_done) state_next = S_SX_MUL;
      end
      S_SX_MUL: begin
        mul_req.start = !launched;
        mul_req.a = {16'h0, sy};
        mul_req.b = {19'h0, tex_w_n};
        if (mul_done) state_next = S_SX_DIV;
      end
      S_SX_DIV: begin
        div_req.start = !launched;
        div_req.count = DIV_CW'(61);
        div_req.dividend = {mul_prod[60:0], 3'h0};
        div_req.divisor = {27'h0, tex_h_n};
        if (div_done) state_next = S_HW_MUL;
      end
      S_HW_MUL: begin
        mul_req.start = !launched;
        mul_req.a = {13'h0, sxw};
        mul_req.b = {20'h0, rays_n};
        if (mul_done) state_next = S_HW_DIV;
      end
      S_HW_DIV: begin
        // the 2^17 of the divisor is dropped from the dividend first
        div_req.start = !launched;
        div_req.count = DIV_CW'(46);
        div_req.dividend = {mul_prod[62:17], 18'h0};
        div_req.divisor = {28'h0, scr_w_n};
        if (div_done) state_next = S_SH_DIV;
      end
      S_SH_DIV: begin
        if ({3'b000, dep} >= c_lim) begin
          state_next = S_FIN;
        end else begin
          div_req.start = !launched;
          div_req.count = DIV_CW'(43);
          div_req.dividend = {sh_num, 21'h0};
          div_req.divisor = {5'h0, c_lim};
          if (div_done) state_next = S_FIN;
        end
      end
      S_COL: state_next = drawn_c ? S_TX_DIV : S_FIN;
      S_TX_DIV: begin
        div_req.start = !launched;
        div_req.count = DIV_CW'(29);
        div_req.dividend = {txp, 35'h0};
        div_req.divisor = {24'h0, span};
        if (div_done) state_next = S_DX_DIV;
      end
      S_DX_DIV: begin
        div_req.start = !launched;
        div_req.count = DIV_CW'(24);
        div_req.dividend = {ixw, 40'h0};
        div_req.divisor = {28'h0, rays_n};
        if (div_done) state_next = S_DW_DIV;
      end
      S_DW_DIV: begin
        div_req.start = !launched;
        div_req.count = DIV_CW'(13);
        div_req.dividend = {wr, 51'h0};
        div_req.divisor = {28'h0, rays_n};
        if (div_done) state_next = S_FIN;
      end
      S_FIN: if (!result_valid || result_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign item_ready = (state == S_IDLE);
  assign load = (state == S_FIN) && (!result_valid || result_ready);

  bsp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  bsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
      result_valid <= 1'b0;
      cfg_fov <= FOV_RST;
      cfg_cell <= CELL_RST;
      cfg_dov <= DOV_RST;
      cfg_rays <= RAYS_RST;
      cfg_scr_w <= SCR_W_RST;
      cfg_scr_h <= SCR_H_RST;
      cfg_tex_w <= TEX_W_RST;
      cfg_tex_h <= TEX_H_RST;
      is_visible <= 1'b0;
      centre_ray <= '0;
      sprite_depth <= 32'h0001_0000;
      half_width_rays <= '0;
    end else begin
      if (mul_req.start || div_req.start) launched <= 1'b1;
      else if (mul_done || div_done) launched <= 1'b0;
      if (load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          CFG_FOV: cfg_fov <= cfg_data[7:0];
          CFG_CELL: cfg_cell <= cfg_data[10:0];
          CFG_DOV: cfg_dov <= cfg_data[7:0];
          CFG_RAYS: cfg_rays <= cfg_data[11:0];
          CFG_SCR_W: cfg_scr_w <= cfg_data[11:0];
          CFG_SCR_H: cfg_scr_h <= cfg_data[11:0];
          CFG_TEX_W: cfg_tex_w <= cfg_data;
          CFG_TEX_H: cfg_tex_h <= cfg_data;
          default: ;
        endcase
      end
      if (load && (act == ACT_PROJECT)) begin
        is_visible <= !hid;
        if (!hid) begin
          centre_ray <= cen;
          sprite_depth <= dep;
          half_width_rays <= hw;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          act <= action;
          ang <= viewer_angle;
          scl <= sprite_scale;
          col <= column;
          cdep <= column_depth;
          dx <= {{3{dxw[32]}}, dxw, 8'h00};
          dy <= {{3{dyw[32]}}, dyw, 8'h00};
        end
      end
      S_VEC_INIT: begin
        step <= '0;
        if (dx[43]) begin
          if (!dy[43]) begin
            x <= dy;
            y <= -dx;
            z <= 32'h4000_0000;
          end else begin
            x <= -dy;
            y <= dx;
            z <= 32'hC000_0000;
          end
        end else begin
          x <= dx;
          y <= dy;
          z <= '0;
        end
      end
      S_VEC: begin
        step <= step + 1'b1;
        if (!y[43]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end
      end
      S_CHECK: begin
        d <= dcalc;
        hid <= hidden;
      end
      S_ROT_INIT: begin
        step <= '0;
        z <= rot_r;
        case (rot_k)
          2'd0: begin x <= dx; y <= dy; end
          2'd1: begin x <= -dy; y <= dx; end
          2'd2: begin x <= -dx; y <= -dy; end
          default: begin x <= dy; y <= -dx; end
        endcase
      end
      S_ROT: begin
        step <= step + 1'b1;
        if (!z[31]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
      end
      S_DEP: begin
        if (x_nonpos) begin
          dep <= 32'h0001_0000;
        end else if (mul_done) begin
          if (mul_prod[95:72] != '0) dep <= 32'hFFFF_FFFF;
          else if (mul_prod[71:56] == '0) dep <= 32'h0001_0000;
          else dep <= mul_prod[71:40];
        end
      end
      S_CEN_DIV: begin
        if (div_done) begin
          if (cen_s > 23'sd32767) cen <= 16'sh7FFF;
          else if (cen_s < -23'sd32768) cen <= -16'sh8000;
          else cen <= cen_s[15:0];
        end
      end
      S_SS_DIV: if (div_done) ss <= div_quo[39:0];
      S_SY_MUL: if (mul_done) sy <= mul_prod[55:8];
      S_SX_DIV: begin
        if (div_done) begin
          // width capped at 2^50
          if ((div_quo[60:51] != '0) || (div_quo[50] && (div_quo[49:0] != '0)))
            sxw <= {1'b1, 50'h0};
          else
            sxw <= div_quo[50:0];
        end
      end
      S_HW_DIV: begin
        if (div_done) hw <= (div_quo[45:15] != '0) ? 15'h7FFF : div_quo[14:0];
      end
      S_SH_DIV: begin
        if ({3'b000, dep} >= c_lim) shade_r <= '0;
        else if (div_done) shade_r <= div_quo[7:0];
      end
      S_COL: begin
        drawn <= drawn_c;
        off <= 16'(iv - st);
        span <= {half_width_rays, 1'b0};
      end
      S_TX_DIV: if (div_done) tx <= (tx_c > 13'd4095) ? 12'hFFF : tx_c[11:0];
      S_DX_DIV: if (div_done) dxo <= div_quo[11:0];
      S_DW_DIV: if (div_done) dwo <= div_quo[11:0];
      default: ;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      visible <= 1'b0;
      center_column <= '0;
      depth <= '0;
      sprite_height <= '0;
      top_row <= '0;
      shade <= '0;
      column_drawn <= 1'b0;
      texture_column <= '0;
      dest_x <= '0;
      dest_width <= '0;
      if (act == ACT_PROJECT) begin
        if (!hid) begin
          visible <= 1'b1;
          center_column <= cen;
          depth <= dep;
          sprite_height <= hgt_c;
          top_row <= top_c;
          shade <= shade_r;
        end
      end else begin
        visible <= is_visible;
        if (drawn) begin
          column_drawn <= 1'b1;
          texture_column <= tx;
          dest_x <= dxo;
          dest_width <= dwo;
        end
      end
    end
  end

endmodule

FILE: sv/bsp_checker.sv
module bsp_checker (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_ready,
  input logic visible,
  input logic signed [15:0] center_column,
  input logic [31:0] depth,
  input logic column_drawn,
  input logic [11:0] dest_width
);

  // a waiting result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(depth) && $stable(column_drawn))
    else $error("result beat changed while stalled");

  // nothing left over from reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // hidden sprite gives an empty result
  a_hidden: assert property (@(posedge clk) disable iff (rst)
    result_valid && !visible |-> !column_drawn && depth == 32'h0 && center_column == 16'sh0)
    else $error("hidden sprite result not empty");

  // a drawn strip needs a visible sprite and a real width, and reports no depth
  a_drawn: assert property (@(posedge clk) disable iff (rst)
    result_valid && column_drawn |-> visible && dest_width != 12'h0 && depth == 32'h0)
    else $error("drawn strip inconsistent");

  // a projection result never reports depth below 1.0
  a_depth: assert property (@(posedge clk) disable iff (rst)
    result_valid && depth != 32'h0 |-> depth >= 32'h0001_0000 && !column_drawn)
    else $error("projected depth below one");

endmodule

bind billboard_sprite_projector bsp_checker u_bsp_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .visible       (visible),
  .center_column (center_column),
  .depth         (depth),
  .column_drawn  (column_drawn),
  .dest_width    (dest_width)
);
